@@ sv/scalar_kalman_filter_bank_top_macros.svh @@
// ----------------------------------------------------------------------------
// Scalar Kalman filter bank assertion macros
// Shared concurrent assertion forms for the bank's checker.
// ----------------------------------------------------------------------------
`ifndef SCALAR_KALMAN_FILTER_BANK_TOP_MACROS_SVH
`define SCALAR_KALMAN_FILTER_BANK_TOP_MACROS_SVH

// next-cycle implication, masked while reset is asserted
`define SKFB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) else $error(msg);

// next-cycle implication, also checked through reset
`define SKFB_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/skfb_pkg.sv @@
// ----------------------------------------------------------------------------
// skfb_pkg
// Types, constants and fixed-point helpers of the scalar Kalman filter bank.
// ----------------------------------------------------------------------------
package skfb_pkg;

    // bank size default
    localparam int NUM_PILOTS_DEF = 64;

    // field widths
    localparam int IDX_W     = 6;
    localparam int VAL_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 40;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STATE_TRANSITION = 3'd0,
        CFG_NOISE_GAIN       = 3'd1,
        CFG_MEAS_GAIN        = 3'd2,
        CFG_PROC_NOISE_VAR   = 3'd3,
        CFG_MEAS_NOISE_VAR   = 3'd4,
        CFG_INIT_COV         = 3'd5
    } t_cfg_idx;

    // configuration reset values
    localparam logic signed [VAL_W-1:0] RST_F  = 16'sd4096;
    localparam logic signed [VAL_W-1:0] RST_G  = 16'sd4096;
    localparam logic signed [VAL_W-1:0] RST_H  = 16'sd4096;
    localparam logic [VAL_W-1:0]        RST_R1 = 16'd410;
    localparam logic [VAL_W-1:0]        RST_R2 = 16'd410;
    localparam logic [VAL_W-1:0]        RST_Q0 = 16'd410;

    // pipeline geometry
    localparam int DIV_STEPS  = 16;
    localparam int DIV_LAT    = DIV_STEPS + 3;
    localparam int DIV_STAGE  = 8;
    localparam int PIPE_LEN   = DIV_STAGE + DIV_LAT + 2;
    localparam int FIFO_DEPTH = 32;
    localparam int CRD_W      = $clog2(FIFO_DEPTH + 1);

    // per-stage item tag and carried operands
    typedef struct packed {
        logic                    valid;
        logic                    wr;
        logic                    first;
        logic [IDX_W-1:0]        idx;
        logic signed [VAL_W-1:0] meas;
        logic signed [VAL_W-1:0] x0;
        logic signed [VAL_W-1:0] xp;
        logic signed [VAL_W:0]   err;
        logic [VAL_W-1:0]        p;
    } t_side;

    // gain divider request
    typedef struct packed {
        logic [56:0] num;
        logic [47:0] den;
        logic        neg;
        logic        zero;
    } t_div_req;

    // one result
    typedef struct packed {
        logic [VAL_W-1:0]        cov;
        logic signed [VAL_W-1:0] xf;
        logic [IDX_W-1:0]        idx;
    } t_result;

    // arithmetic shift right, rounding to nearest with ties away from zero
    function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                   input int unsigned sh);
        logic        neg;
        logic [63:0] mag;
        neg = v[63];
        mag = neg ? 64'(-v) : 64'(v);
        mag = (mag + (64'd1 << (sh - 1))) >> sh;
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic signed [VAL_W-1:0] sat_s16(input logic signed [63:0] v);
        if (v > 64'sd32767) begin
            return 16'sh7fff;
        end else if (v < -64'sd32768) begin
            return 16'sh8000;
        end
        return v[VAL_W-1:0];
    endfunction

    function automatic logic [VAL_W-1:0] sat_u16(input logic signed [63:0] v);
        if (v > 64'sd65535) begin
            return 16'hffff;
        end else if (v < 64'sd0) begin
            return 16'h0000;
        end
        return v[VAL_W-1:0];
    endfunction

endpackage

@@ sv/skfb_state_mem.sv @@
// ----------------------------------------------------------------------------
// skfb_state_mem
// Per-pilot estimate and covariance store, one write and one registered read.
// ----------------------------------------------------------------------------
module skfb_state_mem #(
    parameter int DEPTH = skfb_pkg::NUM_PILOTS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                       i_clk,
    input  logic [AW-1:0]              i_rd_addr,
    output logic [skfb_pkg::VAL_W-1:0] o_rd_est,
    output logic [skfb_pkg::VAL_W-1:0] o_rd_cov,
    input  logic                       i_wr_en,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic [skfb_pkg::VAL_W-1:0] i_wr_est,
    input  logic [skfb_pkg::VAL_W-1:0] i_wr_cov
);
    import skfb_pkg::*;

    logic [2*VAL_W-1:0] r_mem [DEPTH];
    logic [2*VAL_W-1:0] r_rd;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_est, i_wr_cov};
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[i_rd_addr];
    end

    assign o_rd_est = r_rd[2*VAL_W-1:VAL_W];
    assign o_rd_cov = r_rd[VAL_W-1:0];

endmodule

@@ sv/skfb_div.sv @@
// ----------------------------------------------------------------------------
// skfb_div
// Pipelined restoring divider for the Kalman gain, one quotient bit a stage.
// ----------------------------------------------------------------------------
module skfb_div (
    input  logic                              i_clk,
    input  skfb_pkg::t_div_req                i_req,
    output logic signed [skfb_pkg::VAL_W-1:0] o_gain
);
    import skfb_pkg::*;

    t_div_req                r_in;
    logic [63:0]             r_rem  [0:DIV_STEPS];
    logic [63:0]             r_den  [0:DIV_STEPS];
    logic [DIV_STEPS-1:0]    r_q    [0:DIV_STEPS];
    logic                    r_neg  [0:DIV_STEPS];
    logic                    r_zero [0:DIV_STEPS];
    logic                    r_ovf  [0:DIV_STEPS];
    logic signed [VAL_W-1:0] r_gain;
    logic signed [VAL_W-1:0] n_gain;

    // input register
    always_ff @(posedge i_clk) begin
        r_in <= i_req;
    end

    // overflow check: quotient would not fit the bit count
    always_ff @(posedge i_clk) begin
        r_rem[0]  <= 64'(r_in.num);
        r_den[0]  <= 64'(r_in.den);
        r_q[0]    <= '0;
        r_neg[0]  <= r_in.neg;
        r_zero[0] <= r_in.zero;
        r_ovf[0]  <= 64'(r_in.num) >= (64'(r_in.den) << DIV_STEPS);
    end

    // one quotient bit per stage, MSB first
    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
        logic [63:0] trial;
        assign trial = r_den[i] << (DIV_STEPS - 1 - i);

        always_ff @(posedge i_clk) begin
            if (r_rem[i] >= trial) begin
                r_rem[i+1] <= r_rem[i] - trial;
                r_q[i+1]   <= r_q[i] | (DIV_STEPS'(1) << (DIV_STEPS - 1 - i));
            end else begin
                r_rem[i+1] <= r_rem[i];
                r_q[i+1]   <= r_q[i];
            end
            r_den[i+1]  <= r_den[i];
            r_neg[i+1]  <= r_neg[i];
            r_zero[i+1] <= r_zero[i];
            r_ovf[i+1]  <= r_ovf[i];
        end
    end

    // sign and saturation
    always_comb begin
        if (r_zero[DIV_STEPS]) begin
            n_gain = '0;
        end else if (r_neg[DIV_STEPS]) begin
            if (r_ovf[DIV_STEPS] || (r_q[DIV_STEPS] > 16'd32768)) begin
                n_gain = 16'sh8000;
            end else begin
                n_gain = -$signed(r_q[DIV_STEPS]);
            end
        end else begin
            if (r_ovf[DIV_STEPS] || r_q[DIV_STEPS][DIV_STEPS-1]) begin
                n_gain = 16'sh7fff;
            end else begin
                n_gain = $signed(r_q[DIV_STEPS]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_gain <= n_gain;
    end

    assign o_gain = r_gain;

endmodule

@@ sv/skfb_out_fifo.sv @@
// ----------------------------------------------------------------------------
// skfb_out_fifo
// Result queue between the filter pipeline and the output stream.
// ----------------------------------------------------------------------------
module skfb_out_fifo #(
    parameter int DEPTH = skfb_pkg::FIFO_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  skfb_pkg::t_result i_data,
    input  logic              i_pop,
    output logic              o_valid,
    output skfb_pkg::t_result o_data
);
    import skfb_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_result         r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            pop_ok;

    assign pop_ok = i_pop && (r_count != '0);

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CW'(i_push) - CW'(pop_ok);
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule

@@ sv/scalar_kalman_filter_bank_top.sv @@
// ----------------------------------------------------------------------------
// scalar_kalman_filter_bank_top
// Bank of scalar Kalman filters, one per pilot, with state kept in memory.
// ----------------------------------------------------------------------------
// Takes one measurement transfer per clock and returns one result per
// measurement, in order, once the output side is ready. The rate is set by
// the state memory's read-modify-write: a measurement without the
// first-symbol flag for a pilot that still has an item in the 29-stage
// filter pipeline is held off until that item has written its estimate
// back. Up to 32 results may be outstanding; beyond that the input waits
// for the output queue. The state memory needs no clearing after reset;
// each pilot must start with a first-symbol measurement.
module scalar_kalman_filter_bank_top #(
    parameter int NUM_PILOTS = skfb_pkg::NUM_PILOTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // config port
    input  logic                           i_cfg_wr_en,
    input  logic [skfb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [skfb_pkg::VAL_W-1:0]     i_cfg_data,
    // input stream
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // [5:0] pilot_index, [21:6] measurement, [37:22] initial_estimate
    input  logic [skfb_pkg::S_DATA_W-1:0]  i_s_tdata,
    // [0] first_symbol
    input  logic [0:0]                     i_s_tuser,
    // result stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [5:0] out_pilot_index, [21:6] filtered_estimate, [37:22] error_covariance
    output logic [skfb_pkg::M_DATA_W-1:0]  o_m_tdata
);
    import skfb_pkg::*;

    localparam int AW = (NUM_PILOTS > 1) ? $clog2(NUM_PILOTS) : 1;
    localparam logic [10:0] NP_W = 11'(NUM_PILOTS);

    // configuration registers
    logic signed [VAL_W-1:0] r_f, r_g, r_h;
    logic [VAL_W-1:0]        r_r1, r_r2, r_q0;

    // pipeline tags
    t_side r_pipe [1:PIPE_LEN];
    t_side n_pipe [1:PIPE_LEN];

    // stage operands
    logic signed [31:0] r_s2_fx;
    logic [30:0]        r_s2_ff;
    logic [VAL_W-1:0]   r_s2_q;
    logic [46:0]        r_s3_ffq;
    logic [30:0]        r_s3_gg;
    logic [46:0]        r_s4_ffq;
    logic [46:0]        r_s4_ggr1;
    logic signed [31:0] r_s4_hxp;
    logic signed [32:0] r_s6_num;
    logic [30:0]        r_s6_hh;
    logic [46:0]        r_s7_hhp;
    logic [31:0]        r_s7_mag;
    logic               r_s7_neg;
    logic [47:0]        r_s8_den;
    logic [31:0]        r_s8_mag;
    logic               r_s8_neg;
    logic signed [32:0] r_s28_le;
    logic signed [31:0] r_s28_lh;
    logic signed [15:0] r_s29_xf;
    logic signed [48:0] r_s29_lhp;
    logic [CRD_W-1:0]   r_credit;

    // combinational
    logic                    in_accept;
    logic                    in_first;
    logic [IDX_W-1:0]        in_idx;
    logic                    in_inside;
    logic                    hazard;
    logic [VAL_W-1:0]        rd_est;
    logic [VAL_W-1:0]        rd_cov;
    logic signed [VAL_W-1:0] s1_x;
    logic [VAL_W-1:0]        s1_q;
    logic signed [31:0]      s1_fx;
    logic signed [31:0]      s1_ff;
    logic signed [31:0]      s2_gg;
    logic [47:0]             s4_psum;
    logic [23:0]             s4_prnd;
    logic [VAL_W-1:0]        s4_p;
    logic signed [VAL_W-1:0] s4_yh;
    logic signed [32:0]      s5_num;
    logic signed [31:0]      s5_hh;
    logic signed [32:0]      s6_abs;
    logic [47:0]             s7_den;
    t_div_req                div_req;
    logic signed [VAL_W-1:0] gain;
    logic signed [63:0]      s29_qv;
    logic [VAL_W-1:0]        s29_qn;
    t_result                 res_push;
    t_result                 res_out;
    logic                    out_pop;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f  <= RST_F;
            r_g  <= RST_G;
            r_h  <= RST_H;
            r_r1 <= RST_R1;
            r_r2 <= RST_R2;
            r_q0 <= RST_Q0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_STATE_TRANSITION: r_f  <= $signed(i_cfg_data);
                CFG_NOISE_GAIN:       r_g  <= $signed(i_cfg_data);
                CFG_MEAS_GAIN:        r_h  <= $signed(i_cfg_data);
                CFG_PROC_NOISE_VAR:   r_r1 <= i_cfg_data;
                CFG_MEAS_NOISE_VAR:   r_r2 <= i_cfg_data;
                CFG_INIT_COV:         r_q0 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input decode
    assign in_idx    = i_s_tdata[IDX_W-1:0];
    assign in_first  = i_s_tuser[0];
    assign in_inside = {5'd0, in_idx} < NP_W;

    // interlock: a stored-state read must not pass a pending write-back
    always_comb begin
        hazard = 1'b0;
        for (int k = 1; k <= PIPE_LEN; k++) begin
            if (r_pipe[k].valid && r_pipe[k].wr && (r_pipe[k].idx == in_idx)) begin
                hazard = 1'b1;
            end
        end
        hazard = hazard && !in_first;
    end

    assign o_s_tready = (r_credit < CRD_W'(FIFO_DEPTH)) && !hazard;
    assign in_accept  = i_s_tvalid && o_s_tready;
    assign out_pop    = o_m_tvalid && i_m_tready;

    // outstanding result count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else begin
            r_credit <= r_credit + CRD_W'(in_accept) - CRD_W'(out_pop);
        end
    end

    // state store
    skfb_state_mem #(
        .DEPTH (NUM_PILOTS),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_addr (AW'(in_idx)),
        .o_rd_est  (rd_est),
        .o_rd_cov  (rd_cov),
        .i_wr_en   (r_pipe[PIPE_LEN].valid && r_pipe[PIPE_LEN].wr),
        .i_wr_addr (AW'(r_pipe[PIPE_LEN].idx)),
        .i_wr_est  (r_s29_xf),
        .i_wr_cov  (s29_qn)
    );

    // stage 1: pick prior state, predict numerator
    always_comb begin
        if (r_pipe[1].first) begin
            s1_x = r_pipe[1].x0;
            s1_q = r_q0;
        end else if (r_pipe[1].wr) begin
            s1_x = $signed(rd_est);
            s1_q = rd_cov;
        end else begin
            s1_x = '0;
            s1_q = '0;
        end
        s1_fx = r_f * s1_x;
        s1_ff = r_f * r_f;
        s2_gg = r_g * r_g;
    end

    // stage 4: predicted covariance and measurement
    always_comb begin
        s4_psum = 48'(r_s4_ffq) + 48'(r_s4_ggr1);
        s4_prnd = 24'((s4_psum + 48'(1 << 23)) >> 24);
        s4_p    = (s4_prnd > 24'd65535) ? 16'hffff : s4_prnd[VAL_W-1:0];
        s4_yh   = sat_s16(rnd_shr(64'(r_s4_hxp), 12));
    end

    // stages 5..8: gain numerator and denominator
    always_comb begin
        s5_num = $signed({1'b0, r_pipe[5].p}) * r_h;
        s5_hh  = r_h * r_h;
        s6_abs = r_s6_num[32] ? -r_s6_num : r_s6_num;
        s7_den = 48'(r_s7_hhp) + (48'(r_r2) << 24);
        div_req.num  = (57'(r_s8_mag) << 24) + 57'(r_s8_den >> 1);
        div_req.den  = r_s8_den;
        div_req.neg  = r_s8_neg;
        div_req.zero = (r_s8_den == '0);
    end

    skfb_div u_div (
        .i_clk  (i_clk),
        .i_req  (div_req),
        .o_gain (gain)
    );

    // final stage: updated covariance
    always_comb begin
        s29_qv = $signed(64'(r_pipe[PIPE_LEN].p) << 24) - 64'(r_s29_lhp);
        s29_qn = sat_u16(rnd_shr(s29_qv, 24));
    end

    // tag line
    always_comb begin
        n_pipe[1]       = '0;
        n_pipe[1].valid = in_accept;
        n_pipe[1].wr    = in_inside;
        n_pipe[1].first = in_first;
        n_pipe[1].idx   = in_idx;
        n_pipe[1].meas  = $signed(i_s_tdata[21:6]);
        n_pipe[1].x0    = $signed(i_s_tdata[37:22]);
        for (int k = 2; k <= PIPE_LEN; k++) begin
            n_pipe[k] = r_pipe[k-1];
        end
        n_pipe[3].xp  = sat_s16(rnd_shr(64'(r_s2_fx), 12));
        n_pipe[5].err = 17'(r_pipe[4].meas) - 17'(s4_yh);
        n_pipe[5].p   = s4_p;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= PIPE_LEN; k++) begin
                r_pipe[k].valid <= 1'b0;
            end
        end else begin
            r_pipe <= n_pipe;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_s2_fx   <= s1_fx;
        r_s2_ff   <= s1_ff[30:0];
        r_s2_q    <= s1_q;
        r_s3_ffq  <= r_s2_ff * r_s2_q;
        r_s3_gg   <= s2_gg[30:0];
        r_s4_ffq  <= r_s3_ffq;
        r_s4_ggr1 <= r_s3_gg * r_r1;
        r_s4_hxp  <= r_h * r_pipe[3].xp;
        r_s6_num  <= s5_num;
        r_s6_hh   <= s5_hh[30:0];
        r_s7_hhp  <= r_s6_hh * r_pipe[6].p;
        r_s7_mag  <= s6_abs[31:0];
        r_s7_neg  <= r_s6_num[32];
        r_s8_den  <= s7_den;
        r_s8_mag  <= r_s7_mag;
        r_s8_neg  <= r_s7_neg;
        r_s28_le  <= gain * r_pipe[PIPE_LEN-2].err;
        r_s28_lh  <= gain * r_h;
        r_s29_xf  <= sat_s16(64'(r_pipe[PIPE_LEN-1].xp) + rnd_shr(64'(r_s28_le), 12));
        r_s29_lhp <= r_s28_lh * $signed({1'b0, r_pipe[PIPE_LEN-1].p});
    end

    // result queue
    assign res_push.idx = r_pipe[PIPE_LEN].idx;
    assign res_push.xf  = r_s29_xf;
    assign res_push.cov = s29_qn;

    skfb_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_pipe[PIPE_LEN].valid),
        .i_data  (res_push),
        .i_pop   (out_pop),
        .o_valid (o_m_tvalid),
        .o_data  (res_out)
    );

    assign o_m_tdata = {2'b00, res_out.cov, res_out.xf, res_out.idx};

endmodule

@@ sv/skfb_checker.sv @@
// ----------------------------------------------------------------------------
// skfb_checker
// Port-level checks of the scalar Kalman filter bank, bound to the top level.
// ----------------------------------------------------------------------------
`include "scalar_kalman_filter_bank_top_macros.svh"

module skfb_checker #(
    parameter int NUM_PILOTS = skfb_pkg::NUM_PILOTS_DEF
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_cfg_wr_en,
    input logic [skfb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input logic [skfb_pkg::VAL_W-1:0]     i_cfg_data,
    input logic                           i_s_tvalid,
    input logic                           o_s_tready,
    input logic [skfb_pkg::S_DATA_W-1:0]  i_s_tdata,
    input logic [0:0]                     i_s_tuser,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [skfb_pkg::M_DATA_W-1:0]  o_m_tdata
);
    import skfb_pkg::*;

    // after reset: nothing pending, input open
    `SKFB_ASSERT_NEXT_ALWAYS(a_reset_idle, i_clk, !i_rst_n, !o_m_tvalid && o_s_tready, "not idle after reset")

    // same pilot cannot re-read its state in the very next cycle
    `SKFB_ASSERT_NEXT(a_state_interlock, i_clk, i_rst_n, i_s_tvalid && o_s_tready && (32'(i_s_tdata[5:0]) < NUM_PILOTS), !(i_s_tvalid && o_s_tready && !i_s_tuser[0] && (i_s_tdata[5:0] == $past(i_s_tdata[5:0]))), "state read passed pending write-back")

    // stalled result stays offered
    `SKFB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid, "result dropped while stalled")

    // stalled result keeps its payload
    `SKFB_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, $stable(o_m_tdata), "result changed while stalled")

endmodule

bind scalar_kalman_filter_bank_top skfb_checker #(
    .NUM_PILOTS (NUM_PILOTS)
) u_skfb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_wr_en (i_cfg_wr_en),
    .i_cfg_index (i_cfg_index),
    .i_cfg_data  (i_cfg_data),
    .i_s_tvalid  (i_s_tvalid),
    .o_s_tready  (o_s_tready),
    .i_s_tdata   (i_s_tdata),
    .i_s_tuser   (i_s_tuser),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata)
);

@@ tb/scalar_kalman_filter_bank_top_tb.sv @@
// ----------------------------------------------------------------------------
// scalar_kalman_filter_bank_top_tb
// Self-checking bench for the pilot Kalman filter bank. Streams measurements
// under random idle bursts on both sides, predicts every result with its own
// fixed-point filter model and compares results in order, field by field,
// across several register settings.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_bank_top_tb;
    import skfb_pkg::*;

    localparam int BANK        = 64;
    localparam int DRAIN_WAIT  = 40;
    localparam int STALL_LIMIT = 5000;

    typedef struct {
        logic [IDX_W-1:0]        idx;
        logic signed [VAL_W-1:0] xf;
        logic [VAL_W-1:0]        cov;
    } t_expect;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [VAL_W-1:0]     i_cfg_data;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [S_DATA_W-1:0]  i_s_tdata;
    logic [0:0]           i_s_tuser;
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [M_DATA_W-1:0]  o_m_tdata;

    // filter registers as the model sees them
    longint f_gain, g_gain, h_gain, r1_var, r2_var, q0_var;
    // per-pilot filter state
    logic signed [VAL_W-1:0] est_mem [BANK];
    logic [VAL_W-1:0]        cov_mem [BANK];
    bit                      started [BANK];

    t_expect pending_results[$];
    int      errors;
    bit      no_idle;
    int      hold_left;
    int      quiet_cycles;
    bit      timed_out;

    scalar_kalman_filter_bank_top dut (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // round to nearest, ties away from zero, positive divisor
    function automatic longint rnd_div(input longint num, input longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint clip_s16(input longint v);
        return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
    endfunction

    function automatic longint clip_u16(input longint v);
        return (v > 65535) ? 65535 : ((v < 0) ? 0 : v);
    endfunction

    // one filter update; returns the result and updates the pilot's state
    function automatic t_expect kalman_update(input logic [IDX_W-1:0] idx,
                                              input logic signed [VAL_W-1:0] y,
                                              input bit first,
                                              input logic signed [VAL_W-1:0] x0);
        t_expect r;
        longint x, q, xp, yh, p, num, den, l, xf, qn;
        if (first) begin
            x = longint'(x0);
            q = q0_var;
        end else begin
            x = longint'(est_mem[idx]);
            q = longint'(cov_mem[idx]);
        end
        xp  = clip_s16(rnd_div(f_gain * x, 4096));
        yh  = clip_s16(rnd_div(h_gain * xp, 4096));
        p   = clip_u16(rnd_div(f_gain * f_gain * q + g_gain * g_gain * r1_var,
                               64'd1 << 24));
        num = p * h_gain;
        den = h_gain * h_gain * p + r2_var * (64'd1 << 24);
        l   = (den > 0) ? clip_s16(rnd_div(num * (64'd1 << 24), den)) : 0;
        xf  = clip_s16(xp + rnd_div(l * (longint'(y) - yh), 4096));
        qn  = clip_u16(rnd_div(p * (64'd1 << 24) - l * h_gain * p, 64'd1 << 24));
        est_mem[idx] = xf[VAL_W-1:0];
        cov_mem[idx] = qn[VAL_W-1:0];
        started[idx] = 1'b1;
        r.idx = idx;
        r.xf  = xf[VAL_W-1:0];
        r.cov = qn[VAL_W-1:0];
        return r;
    endfunction

    // send one measurement; returns after its transfer edge
    task automatic send_meas(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] y,
                             input bit first, input logic [VAL_W-1:0] x0);
        int gap;
        @(negedge i_clk);
        if (!no_idle && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tdata  <= {2'b00, x0, y, idx};
        i_s_tuser  <= first;
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        pending_results.push_back(kalman_update(idx, y, first, x0));
    endtask

    task automatic end_burst();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        wait (pending_results.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx sel, input logic [VAL_W-1:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (sel)
            CFG_STATE_TRANSITION: f_gain = longint'($signed(val));
            CFG_NOISE_GAIN:       g_gain = longint'($signed(val));
            CFG_MEAS_GAIN:        h_gain = longint'($signed(val));
            CFG_PROC_NOISE_VAR:   r1_var = longint'(val);
            CFG_MEAS_NOISE_VAR:   r2_var = longint'(val);
            CFG_INIT_COV:         q0_var = longint'(val);
            default: ;
        endcase
    endtask

    task automatic set_filter(input logic [VAL_W-1:0] f, g, h, r1, r2, q0);
        write_reg(CFG_STATE_TRANSITION, f);
        write_reg(CFG_NOISE_GAIN, g);
        write_reg(CFG_MEAS_GAIN, h);
        write_reg(CFG_PROC_NOISE_VAR, r1);
        write_reg(CFG_MEAS_NOISE_VAR, r2);
        write_reg(CFG_INIT_COV, q0);
    endtask

    // random pilot traffic; pilots never started get a first symbol
    task automatic random_meas(input int count);
        logic [IDX_W-1:0] idx;
        bit               first;
        for (int n = 0; n < count; n++) begin
            idx   = IDX_W'($urandom_range(0, BANK - 1));
            first = !started[idx] || ($urandom_range(0, 7) == 0);
            send_meas(idx, VAL_W'($urandom), first, VAL_W'($urandom));
        end
        end_burst();
    endtask

    // field extremes, first and follow-up symbols at reset settings
    task automatic test_directed();
        send_meas(6'd0, 16'h7fff, 1'b1, 16'h7fff);
        send_meas(6'd63, 16'h8000, 1'b1, 16'h8000);
        send_meas(6'd1, 16'h0000, 1'b1, 16'h0000);
        send_meas(6'd0, 16'h8000, 1'b0, 16'h0000);
        send_meas(6'd63, 16'h7fff, 1'b0, 16'hffff);
        send_meas(6'd1, 16'hffff, 1'b0, 16'h1234);
        send_meas(6'd0, 16'h1000, 1'b1, 16'hf000);
        for (int n = 0; n < 6; n++) begin
            send_meas(6'd0, 16'h1000, 1'b0, 16'h0000);
            send_meas(6'd63, 16'h7fff, 1'b0, 16'h0000);
        end
        end_burst();
    endtask

    // zero denominator: H = 0 and R2 = 0 give zero gain
    task automatic test_zero_gain();
        wait_drained();
        set_filter(16'h1000, 16'h1000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_meas(6'd2, 16'h7fff, 1'b1, 16'h2000);
        send_meas(6'd2, 16'h8000, 1'b0, 16'h0000);
        send_meas(6'd3, 16'h4000, 1'b1, 16'h8000);
        end_burst();
    endtask

    // register extremes and random settings
    task automatic test_settings();
        wait_drained();
        set_filter(16'h7fff, 16'h7fff, 16'h7fff, 16'hffff, 16'hffff, 16'hffff);
        random_meas(150);
        wait_drained();
        set_filter(16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h0000);
        random_meas(150);
        wait_drained();
        set_filter(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hffff, 16'h0000);
        random_meas(100);
        for (int ph = 0; ph < 4; ph++) begin
            wait_drained();
            set_filter(VAL_W'($urandom), VAL_W'($urandom), VAL_W'($urandom),
                       VAL_W'($urandom), VAL_W'($urandom), VAL_W'($urandom));
            random_meas(150);
        end
        wait_drained();
        set_filter(16'h0f00, 16'h0400, 16'h1000, 16'h0100, 16'h0200, 16'h0800);
        random_meas(150);
    endtask

    // output held off long enough to fill the result queue
    task automatic test_backpressure();
        wait_drained();
        hold_left = 300;
        random_meas(80);
    endtask

    // closing stretch without idling on either side
    task automatic test_full_rate();
        wait_drained();
        set_filter(RST_F, RST_G, RST_H, RST_R1, RST_R2, RST_Q0);
        no_idle = 1'b1;
        random_meas(300);
    endtask

    // receiver: random stall bursts and the long hold-off
    initial begin
        int burst;
        burst = 0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (no_idle) begin
                i_m_tready <= 1'b1;
            end else if (burst > 0) begin
                burst--;
                i_m_tready <= 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
                burst = $urandom_range(0, 9);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_expect e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transfer: %h", o_m_tdata);
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (o_m_tdata[5:0] !== e.idx) begin
                    $error("out_pilot_index: expected %0d, got %0d", e.idx, o_m_tdata[5:0]);
                    errors++;
                end
                if (o_m_tdata[21:6] !== e.xf) begin
                    $error("filtered_estimate: expected %0d, got %0d",
                           e.xf, $signed(o_m_tdata[21:6]));
                    errors++;
                end
                if (o_m_tdata[37:22] !== e.cov) begin
                    $error("error_covariance: expected %0d, got %0d", e.cov, o_m_tdata[37:22]);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        errors       = 0;
        no_idle      = 1'b0;
        hold_left    = 0;
        quiet_cycles = 0;
        timed_out    = 1'b0;
        i_rst_n      = 1'b0;
        i_cfg_wr_en  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_s_tuser    = '0;
        f_gain = longint'(RST_F);
        g_gain = longint'(RST_G);
        h_gain = longint'(RST_H);
        r1_var = longint'(RST_R1);
        r2_var = longint'(RST_R2);
        q0_var = longint'(RST_Q0);
        for (int k = 0; k < BANK; k++) begin
            started[k] = 1'b0;
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_zero_gain();
        test_settings();
        test_backpressure();
        test_full_rate();

        wait (pending_results.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
